@@ rtl/cor_pkg.sv @@
// cor_pkg: shared types and constants for the circle outline rasterizer.
// Used by cor_emit and circle_outline_rasterizer_unit; no dependencies.
`timescale 1ns / 1ps

package cor_pkg;

   // field widths
   localparam int CoordW  = 16;   // centre coordinate
   localparam int RadiusW = 14;   // radius / major offset
   localparam int MinorW  = 15;   // minor offset
   localparam int ResidW  = 18;   // midpoint residual
   localparam int PixW    = 17;   // output pixel coordinate
   localparam int RunLen  = 8;    // pixels per step
   localparam int IdxW    = $clog2(RunLen);

   // action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // one step's worth of work for the pixel sequencer
   typedef struct packed {
      logic signed [CoordW-1:0]  cx;
      logic signed [CoordW-1:0]  cy;
      logic        [RadiusW-1:0] major;
      logic        [MinorW-1:0]  minor;
      logic                      fin;
   } run_type;

endpackage

@@ rtl/cor_emit.sv @@
// cor_emit: plays one queued run out as eight pixel beats, one per cycle while
// rsp_stall is low, through a registered output stage. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        run_valid,
   input  cor_pkg::run_type            run,
   output logic                        run_take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [cor_pkg::PixW-1:0] rsp_pixel_x,
   output logic signed [cor_pkg::PixW-1:0] rsp_pixel_y,
   output logic                        rsp_last,
   output logic                        rsp_finished
);
   import cor_pkg::*;

   logic                    cur_valid_ff, cur_valid_in;
   run_type                 cur_ff, cur_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [PixW-1:0]  px_ff, px_in, py_ff, py_in;
   logic                    last_ff, last_in, fin_ff, fin_in;

   logic                    advance, at_end;
   logic signed [PixW-1:0]  cx_e, cy_e, maj_e, min_e;
   logic                    hor_major, hor_minus, ver_major, ver_minus;

   // output slot can take a beat when empty or being drained
   assign advance  = cur_valid_ff && (!out_valid_ff || !rsp_stall);
   assign at_end   = (idx_ff == IdxW'(RunLen - 1));
   assign run_take = run_valid && (!cur_valid_ff || (advance && at_end));

   // operands extended to pixel width
   assign cx_e  = {{(PixW-CoordW){cur_ff.cx[CoordW-1]}}, cur_ff.cx};
   assign cy_e  = {{(PixW-CoordW){cur_ff.cy[CoordW-1]}}, cur_ff.cy};
   assign maj_e = {{(PixW-RadiusW){1'b0}}, cur_ff.major};
   assign min_e = {{(PixW-MinorW){1'b0}}, cur_ff.minor};

   // octant selection by beat index
   always_comb begin
      hor_major = 1'b0;
      hor_minus = 1'b0;
      ver_major = 1'b0;
      ver_minus = 1'b0;
      case (idx_ff)
         3'd0: begin hor_minus = 1'b1; ver_major = 1'b1; ver_minus = 1'b1; end
         3'd1: begin ver_major = 1'b1; ver_minus = 1'b1; end
         3'd2: begin hor_major = 1'b1; ver_minus = 1'b1; end
         3'd3: begin hor_major = 1'b1; hor_minus = 1'b1; ver_minus = 1'b1; end
         3'd4: begin hor_major = 1'b1; hor_minus = 1'b1; end
         3'd5: begin hor_major = 1'b1; end
         3'd6: begin ver_major = 1'b1; end
         3'd7: begin hor_minus = 1'b1; ver_major = 1'b1; end
         default: begin end
      endcase
   end

   // next-state logic
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      fin_in       = fin_ff;

      if (advance) begin
         out_valid_in = 1'b1;
         px_in   = hor_minus ? cx_e - (hor_major ? maj_e : min_e)
                             : cx_e + (hor_major ? maj_e : min_e);
         py_in   = ver_minus ? cy_e - (ver_major ? maj_e : min_e)
                             : cy_e + (ver_major ? maj_e : min_e);
         last_in = at_end;
         fin_in  = at_end && cur_ff.fin;
         idx_in  = idx_ff + 1'b1;
         if (at_end) begin
            cur_valid_in = 1'b0;
         end
      end

      if (run_take) begin
         cur_valid_in = 1'b1;
         cur_in       = run;
         idx_in       = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
      fin_ff  <= fin_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_pixel_x  = px_ff;
   assign rsp_pixel_y  = py_ff;
   assign rsp_last     = last_ff;
   assign rsp_finished = fin_ff;

endmodule

@@ rtl/circle_outline_rasterizer_unit.sv @@
// circle_outline_rasterizer_unit: midpoint circle outline, eight-way symmetry.
// Depends on cor_pkg and cor_emit.
`timescale 1ns / 1ps
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, center_x, center_y, radius
//   rsp      out        rsp_valid/rsp_stall  pixel_x, pixel_y, last, finished
//
// A start or an idle step emits nothing. A step gives eight beats, one per
// cycle while rsp_stall is low, paced by the one-beat-per-cycle output
// register. One step waits in a queue slot while the previous run plays;
// req_stall is high only while that slot is full.
// Reset is synchronous and leaves the block idle with no beats pending.

module circle_outline_rasterizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [cor_pkg::CoordW-1:0]   req_center_x,
   input  logic signed [cor_pkg::CoordW-1:0]   req_center_y,
   input  logic        [cor_pkg::RadiusW-1:0]  req_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cor_pkg::PixW-1:0]     rsp_pixel_x,
   output logic signed [cor_pkg::PixW-1:0]     rsp_pixel_y,
   output logic                                rsp_last,
   output logic                                rsp_finished
);
   import cor_pkg::*;

   localparam int WideW = ResidW + 2;

   logic                       active_ff, active_in;
   logic signed [CoordW-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic        [RadiusW-1:0]  major_ff, major_in;
   logic        [MinorW-1:0]   minor_ff, minor_in;
   logic signed [ResidW-1:0]   resid_ff, resid_in;
   logic                       pend_valid_ff, pend_valid_in;
   run_type                    pend_ff, pend_in;

   logic                       accept, new_run, pend_take;
   logic signed [WideW-1:0]    od, sd, od_mag, sd_mag;
   logic                       dec_major;
   logic signed [CoordW-1:0]   major_nx, minor_nx;
   logic                       done;

   assign req_stall = pend_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign new_run   = accept && (req_action == ACT_STEP) && active_ff;

   // midpoint residual update
   assign od = {{(WideW-ResidW){resid_ff[ResidW-1]}}, resid_ff}
             + $signed({{(WideW-MinorW-1){1'b0}}, minor_ff, 1'b1});
   assign sd = od - $signed({{(WideW-RadiusW-1){1'b0}}, major_ff, 1'b1});
   assign od_mag    = od[WideW-1] ? -od : od;
   assign sd_mag    = sd[WideW-1] ? -sd : sd;
   assign dec_major = $unsigned(sd_mag) < $unsigned(od_mag);
   assign major_nx  = $signed({{(CoordW-RadiusW){1'b0}}, major_ff})
                    - (dec_major ? CoordW'(1) : CoordW'(0));
   assign minor_nx  = $signed({{(CoordW-MinorW){1'b0}}, minor_ff}) + CoordW'(1);
   assign done      = major_nx < minor_nx;

   // circle state next values
   always_comb begin
      active_in = active_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      resid_in  = resid_ff;
      if (accept && req_action == ACT_START) begin
         active_in = 1'b1;
         cx_in     = req_center_x;
         cy_in     = req_center_y;
         major_in  = req_radius;
         minor_in  = '0;
         resid_in  = '0;
      end else if (new_run) begin
         major_in  = major_nx[RadiusW-1:0];
         minor_in  = minor_nx[MinorW-1:0];
         resid_in  = dec_major ? sd[ResidW-1:0] : od[ResidW-1:0];
         if (done) begin
            active_in = 1'b0;
         end
      end
   end

   // queue slot for one run
   always_comb begin
      pend_valid_in = pend_valid_ff && !pend_take;
      pend_in       = pend_ff;
      if (new_run) begin
         pend_valid_in = 1'b1;
         pend_in.cx    = cx_ff;
         pend_in.cy    = cy_ff;
         pend_in.major = major_ff;
         pend_in.minor = minor_ff;
         pend_in.fin   = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      resid_ff <= resid_in;
      pend_ff  <= pend_in;
   end

   // pixel sequencer
   cor_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .run_valid    (pend_valid_ff),
      .run          (pend_ff),
      .run_take     (pend_take),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_last     (rsp_last),
      .rsp_finished (rsp_finished)
   );

endmodule
